[design/cdgd_pkg.sv]
// cdgd_pkg: shared types and constants for the cloud-in-cell density grid
// used by the front end, the back end and the top level; no dependencies
`default_nettype none

package cdgd_pkg;

    localparam int AXIS_W  = 8;
    localparam int WGT_W   = 16;
    localparam int POS_W   = 32;
    localparam int SCALE_W = 32;
    localparam int IDX_W   = 15;
    localparam int MASS_W  = 40;
    localparam int CON_W   = 48;

    // configuration register indexes
    localparam logic REG_COORD   = 1'b0;
    localparam logic REG_DENSITY = 1'b1;

    typedef enum logic [1:0] {
        OP_DEPOSIT = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        op_t                          op;
        logic [2:0][AXIS_W-1:0]       lo;
        logic [2:0][AXIS_W-1:0]       hi;
        logic [2:0][WGT_W-1:0]        frac;
        logic [IDX_W-1:0]             idx;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

[design/cdgd_fifo.sv]
// cdgd_fifo: two-entry queue used between front and back and on the result side
// no package dependencies
`default_nettype none

module cdgd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [1:0][WIDTH-1:0] store_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[design/cdgd_front.sv]
// cdgd_front: accepts transactions, scales positions and splits them into cells
// and weights with a digit-serial modulo; depends on cdgd_pkg
`default_nettype none

module cdgd_front #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_y,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_z,
    input  wire logic [cdgd_pkg::IDX_W-1:0]          cell_index,
    input  wire logic [cdgd_pkg::SCALE_W-1:0]        coordinate_scale,
    input  wire cdgd_pkg::back_status_t              status,
    output logic                                     cmd_push,
    output cdgd_pkg::cmd_t                           cmd_data,
    input  wire logic                                cmd_full
);

    localparam int AW  = cdgd_pkg::AXIS_W;
    localparam int T_W = AW + 5;
    localparam logic [T_W-1:0] SIDE_T  = T_W'(GRID_SIDE);
    localparam logic [AW:0]    SIDE_E  = (AW + 1)'(GRID_SIDE);
    localparam logic [AW-1:0]  SIDE_M1 = AW'(GRID_SIDE - 1);
    localparam logic [AW-1:0]  WRAP_K  = AW'((64'd1 << 32) % GRID_SIDE);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_REM,
        F_PUSH
    } fstate_t;

    fstate_t                                  state_reg;
    logic [2:0]                               cnt_reg;
    cdgd_pkg::op_t                            op_reg;
    logic [cdgd_pkg::IDX_W-1:0]               idx_reg;
    logic [2:0][cdgd_pkg::POS_W-1:0]          pos_reg;
    logic [2:0][31:0]                         cell_reg;
    logic [2:0]                               neg_reg;
    logic [2:0][cdgd_pkg::WGT_W-1:0]          frac_reg;
    logic [2:0][AW-1:0]                       rem_reg;

    logic signed [32:0]                       scale_s;
    logic signed [64:0]                       prod_w [3];
    logic [T_W-1:0]                           t_w [3];
    logic [2:0][AW-1:0]                       rem_next;
    logic [2:0][AW-1:0]                       lo_w;
    logic [2:0][AW-1:0]                       hi_w;
    logic [AW:0]                              up_w [3];
    logic                                     accept;

    assign full   = (state_reg != F_IDLE) || status.clearing;
    assign accept = push && !full;
    assign scale_s = $signed({1'b0, coordinate_scale});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_w[i] = $signed(pos_reg[i]) * scale_s;
            // one radix-16 digit of the remainder per cycle, msb first
            t_w[i] = {{(T_W - AW - 4){1'b0}}, rem_reg[i], cell_reg[i][31:28]};
            for (int k = 3; k >= 0; k--)
            begin
                if (t_w[i] >= (SIDE_T << k))
                begin
                    t_w[i] = t_w[i] - (SIDE_T << k);
                end
            end
            rem_next[i] = t_w[i][AW-1:0];
            // negative cells were reduced as unsigned, take 2^32 mod side back out
            up_w[i] = {1'b0, rem_reg[i]} + SIDE_E - {1'b0, WRAP_K};
            if (!neg_reg[i])
            begin
                lo_w[i] = rem_reg[i];
            end
            else if (rem_reg[i] >= WRAP_K)
            begin
                lo_w[i] = rem_reg[i] - WRAP_K;
            end
            else
            begin
                lo_w[i] = up_w[i][AW-1:0];
            end
            hi_w[i] = (lo_w[i] == SIDE_M1) ? '0 : lo_w[i] + AW'(1);
        end
    end

    always_comb
    begin
        cmd_data.op   = op_reg;
        cmd_data.lo   = lo_w;
        cmd_data.hi   = hi_w;
        cmd_data.frac = frac_reg;
        cmd_data.idx  = idx_reg;
    end

    assign cmd_push = (state_reg == F_PUSH);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            idx_reg    <= cell_index;
            op_reg     <= cdgd_pkg::op_t'(mode);
        end
        if (state_reg == F_MUL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= prod_w[i][63:32];
                neg_reg[i]  <= prod_w[i][63];
                frac_reg[i] <= prod_w[i][31:16];
                rem_reg[i]  <= '0;
            end
        end
        else if (state_reg == F_REM)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                cell_reg[i] <= {cell_reg[i][27:0], 4'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cdgd_pkg::op_t'(mode))
                            cdgd_pkg::OP_DEPOSIT: state_reg <= F_MUL;
                            cdgd_pkg::OP_READ,
                            cdgd_pkg::OP_CLEAR:   state_reg <= F_PUSH;
                            default:              state_reg <= F_IDLE;
                        endcase
                    end
                end
                F_MUL:
                begin
                    cnt_reg   <= 3'd0;
                    state_reg <= F_REM;
                end
                F_REM:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/cdgd_back.sv]
// cdgd_back: grid memory with clearing sweep, corner read-modify-write, cell clear
// and cell read with density contrast; depends on cdgd_pkg
`default_nettype none

module cdgd_back #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cdgd_pkg::cmd_t                    cmd_data,
    input  wire logic                              cmd_empty,
    output logic                                   cmd_pop,
    input  wire logic [cdgd_pkg::SCALE_W-1:0]      density_scale,
    output logic                                   res_push,
    output logic [cdgd_pkg::MASS_W-1:0]            res_mass,
    output logic [cdgd_pkg::CON_W-1:0]             res_contrast,
    input  wire logic                              res_full,
    output cdgd_pkg::back_status_t                 status
);

    localparam int NCELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(NCELLS);
    localparam int MW     = cdgd_pkg::MASS_W;
    localparam int CW     = cdgd_pkg::CON_W;
    localparam logic [AW-1:0] LAST   = AW'(NCELLS - 1);
    localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);
    localparam logic [16:0]   ONE_W  = 17'd65536;
    localparam logic [56:0]   ONE_Q  = 57'd65536;
    localparam logic [56:0]   CON_MAX = 57'h7FFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_MUL,
        B_WR,
        B_RMUL,
        B_RES
    } bstate_t;

    bstate_t             state_reg;
    logic [2:0]          corner_reg;
    logic [AW-1:0]       clr_reg;
    cdgd_pkg::cmd_t      cmd_reg;

    logic [MW-1:0]       mem [NCELLS];
    logic [MW-1:0]       rdata_reg;
    logic [AW-1:0]       addr_reg;
    logic [33:0]         wxy_reg;
    logic [16:0]         az_reg;
    logic [16:0]         w_reg;
    logic                rvalid_reg;
    logic [MW-1:0]       mass_reg;
    logic [47:0]         p1_reg;
    logic [55:0]         p2_reg;

    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [MW-1:0]       mem_wd;
    logic                idx_ok;
    logic [AW-1:0]       idx_addr;
    logic [AW-1:0]       corner_addr;
    logic [16:0]         ax;
    logic [16:0]         ay;
    logic [16:0]         az;
    logic [50:0]         wprod;
    logic [50:0]         wround;
    logic [MW:0]         sum;
    logic [MW-1:0]       sum_sat;
    logic [MW-1:0]       mass_sel;
    logic [56:0]         q;
    logic [56:0]         diff;

    assign idx_ok   = (32'(cmd_data.idx) < 32'(NCELLS));
    assign idx_addr = AW'(cmd_data.idx);

    always_comb
    begin
        ax = corner_reg[2] ? {1'b0, cmd_reg.frac[0]} : ONE_W - {1'b0, cmd_reg.frac[0]};
        ay = corner_reg[1] ? {1'b0, cmd_reg.frac[1]} : ONE_W - {1'b0, cmd_reg.frac[1]};
        az = corner_reg[0] ? {1'b0, cmd_reg.frac[2]} : ONE_W - {1'b0, cmd_reg.frac[2]};
        corner_addr =
            (AW'(corner_reg[2] ? cmd_reg.hi[0] : cmd_reg.lo[0]) * SIDE_A
             + AW'(corner_reg[1] ? cmd_reg.hi[1] : cmd_reg.lo[1])) * SIDE_A
            + AW'(corner_reg[0] ? cmd_reg.hi[2] : cmd_reg.lo[2]);
    end

    // corner weight rounded half up from q1.48 to q1.16
    assign wprod  = wxy_reg * az_reg;
    assign wround = wprod + 51'h0_8000_0000;

    assign sum     = {1'b0, rdata_reg} + (MW + 1)'(w_reg);
    assign sum_sat = sum[MW] ? {MW{1'b1}} : sum[MW-1:0];

    assign mass_sel = rvalid_reg ? rdata_reg : '0;

    assign q    = {1'b0, p1_reg, 8'd0} + 57'(p2_reg[55:16]);
    assign diff = q - ONE_Q;

    always_comb
    begin
        if (q >= ONE_Q && diff > CON_MAX)
        begin
            res_contrast = CON_MAX[CW-1:0];
        end
        else
        begin
            res_contrast = diff[CW-1:0];
        end
    end

    assign res_mass        = mass_reg;
    assign res_push        = (state_reg == B_RES);
    assign status.clearing = (state_reg == B_CLEAR);
    assign cmd_pop         = (state_reg == B_IDLE) && !cmd_empty;

    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = addr_reg;
        mem_wd   = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            B_IDLE:
            begin
                mem_addr = idx_addr;
                if (!cmd_empty && idx_ok)
                begin
                    mem_re = (cmd_data.op == cdgd_pkg::OP_READ);
                    mem_we = (cmd_data.op == cdgd_pkg::OP_CLEAR);
                end
            end
            B_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = corner_addr;
            end
            B_WR:
            begin
                mem_we = 1'b1;
                mem_wd = sum_sat;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg    <= cmd_data;
            rvalid_reg <= idx_ok;
        end
        if (state_reg == B_RD)
        begin
            addr_reg <= corner_addr;
            wxy_reg  <= ax * ay;
            az_reg   <= az;
        end
        if (state_reg == B_MUL)
        begin
            w_reg <= wround[48:32];
        end
        if (state_reg == B_RMUL)
        begin
            mass_reg <= mass_sel;
            p1_reg   <= density_scale * mass_sel[39:24];
            p2_reg   <= density_scale * mass_sel[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            corner_reg <= 3'd0;
            clr_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        corner_reg <= 3'd0;
                        unique case (cmd_data.op)
                            cdgd_pkg::OP_DEPOSIT: state_reg <= B_RD;
                            cdgd_pkg::OP_READ:    state_reg <= B_RMUL;
                            default:              state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_RD:   state_reg <= B_MUL;
                B_MUL:  state_reg <= B_WR;
                B_WR:
                begin
                    corner_reg <= corner_reg + 3'd1;
                    state_reg  <= (corner_reg == 3'd7) ? B_IDLE : B_RD;
                end
                B_RMUL: state_reg <= B_RES;
                B_RES:
                begin
                    if (!res_full)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("grid memory read and written in one cycle");

    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !cmd_pop)
        else $error("transaction taken during clearing sweep");

    a_corner_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> (corner_reg == 3'd0))
        else $error("corner counter not back at zero");

    a_wr_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WR) |-> ($past(state_reg) == B_MUL))
        else $error("corner write without weight");

endmodule

`default_nettype wire

[design/cic_density_grid_deposit_core.sv]
// Cloud-in-cell density grid: a deposit spreads one Q16.16 particle over the eight
// surrounding cells of a periodic cube, a read returns a cell's mass and density
// contrast, a clear zeroes one cell. After reset the grid is swept to zero, one cell
// per cycle over all GRID_SIDE^3 cells (32768 at the default), and full stays high
// meanwhile. For a deposit the back end takes the transaction and then, for each
// corner, reads, multiplies the weight and does a saturating write on the single-port
// grid memory; the front end does the scaling and the cell wrap, which overlap with
// the previous transaction. Depends on cdgd_pkg, cdgd_fifo, cdgd_front and cdgd_back.
`default_nettype none

module cic_density_grid_deposit_core #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_y,
    input  wire logic signed [cdgd_pkg::POS_W-1:0]   pos_z,
    input  wire logic [cdgd_pkg::IDX_W-1:0]          cell_index,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [cdgd_pkg::MASS_W-1:0]              cell_mass,
    output logic signed [cdgd_pkg::CON_W-1:0]        contrast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [cdgd_pkg::SCALE_W-1:0]        cfg_data
);

    localparam int CMD_W = $bits(cdgd_pkg::cmd_t);
    localparam int RES_W = cdgd_pkg::MASS_W + cdgd_pkg::CON_W;

    logic [cdgd_pkg::SCALE_W-1:0] coord_scale_reg;
    logic [cdgd_pkg::SCALE_W-1:0] dens_scale_reg;

    cdgd_pkg::back_status_t       status;
    cdgd_pkg::cmd_t               front_cmd;
    logic                         front_push;
    logic                         cmdq_full;
    logic [CMD_W-1:0]             cmdq_rdata;
    logic                         cmdq_empty;
    logic                         cmdq_pop;
    logic                         res_push;
    logic                         res_full;
    logic [cdgd_pkg::MASS_W-1:0]  res_mass;
    logic [cdgd_pkg::CON_W-1:0]   res_contrast;
    logic [RES_W-1:0]             resq_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg <= 32'd65536;
            dens_scale_reg  <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cdgd_pkg::REG_COORD:   coord_scale_reg <= cfg_data;
                cdgd_pkg::REG_DENSITY: dens_scale_reg  <= cfg_data;
                default:               coord_scale_reg <= coord_scale_reg;
            endcase
        end
    end

    cdgd_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .mode             (mode),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .cell_index       (cell_index),
        .coordinate_scale (coord_scale_reg),
        .status           (status),
        .cmd_push         (front_push),
        .cmd_data         (front_cmd),
        .cmd_full         (cmdq_full)
    );

    cdgd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (cmdq_pop),
        .rdata (cmdq_rdata),
        .empty (cmdq_empty)
    );

    cdgd_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_data      (cdgd_pkg::cmd_t'(cmdq_rdata)),
        .cmd_empty     (cmdq_empty),
        .cmd_pop       (cmdq_pop),
        .density_scale (dens_scale_reg),
        .res_push      (res_push),
        .res_mass      (res_mass),
        .res_contrast  (res_contrast),
        .res_full      (res_full),
        .status        (status)
    );

    cdgd_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({res_mass, res_contrast}),
        .full  (res_full),
        .pop   (pop),
        .rdata (resq_rdata),
        .empty (empty)
    );

    assign cell_mass = resq_rdata[RES_W-1:cdgd_pkg::CON_W];
    assign contrast  = $signed(resq_rdata[cdgd_pkg::CON_W-1:0]);

endmodule

`default_nettype wire
